[hdl/c_subset_lexer_top_defines.svh]
// assertion macros used by the lexer top level
// no dependencies; clock clk and reset arst_n are taken from the including scope
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH

// condition implies property in the same cycle
`define CSL_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("lexer assertion failed");

// condition implies property in the next cycle
`define CSL_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("lexer assertion failed");

`endif

[hdl/csl_pkg.sv]
// token kinds, character codes and keyword table for the c subset lexer
// no dependencies
package csl_pkg;

	localparam logic [4:0] K_INT    = 5'd0;
	localparam logic [4:0] K_IDENT  = 5'd6;
	localparam logic [4:0] K_NUMBER = 5'd7;
	localparam logic [4:0] K_PLUS   = 5'd8;
	localparam logic [4:0] K_MINUS  = 5'd9;
	localparam logic [4:0] K_MUL    = 5'd10;
	localparam logic [4:0] K_DIV    = 5'd11;
	localparam logic [4:0] K_LPAREN = 5'd12;
	localparam logic [4:0] K_RPAREN = 5'd13;
	localparam logic [4:0] K_LBRACE = 5'd14;
	localparam logic [4:0] K_RBRACE = 5'd15;
	localparam logic [4:0] K_SEMI   = 5'd16;
	localparam logic [4:0] K_ASSIGN = 5'd17;
	localparam logic [4:0] K_LT     = 5'd18;
	localparam logic [4:0] K_GT     = 5'd19;
	localparam logic [4:0] K_EOF    = 5'd20;
	localparam logic [4:0] K_ERROR  = 5'd21;

	localparam int KIND_BITS = 5;
	localparam int QDEPTH    = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// keyword text, first character in the low byte, zero filled
	localparam logic [47:0] KW_TEXT [6] = '{
		48'h0000_0074_6E69,   // int
		48'h6E72_7574_6572,   // return
		48'h0000_0000_6669,   // if
		48'h0000_6573_6C65,   // else
		48'h0000_0072_6F66,   // for
		48'h0065_6C69_6877    // while
	};
	localparam logic [2:0] KW_LEN [6] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd3, 3'd5};

	// unused character slots are zero, so a full compare is enough
	function automatic logic [4:0] kw_kind(input logic [47:0] chars, input logic [2:0] len);
		logic [4:0] k;
		k = K_IDENT;
		for (int i = 5; i >= 0; i--) begin
			if (len == KW_LEN[i] && chars == KW_TEXT[i])
				k = K_INT + 5'(i);
		end
		return k;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
	endfunction

endpackage

[hdl/csl_front.sv]
// front end: scans one byte per transfer, keeps scan state, builds a token bundle
// depends on csl_pkg
module csl_front import csl_pkg::*; #(
	parameter int LINE_BITS  = 16,
	parameter int VALUE_BITS = 31,
	parameter int TOK_W      = KIND_BITS + VALUE_BITS + LINE_BITS,
	parameter int BUN_W      = 2 + 3 * TOK_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       src_byte,
	input  logic             end_of_source,
	output logic             push,
	output logic [BUN_W-1:0] bundle
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_NUM     = 3'd1;
	localparam logic [2:0] M_IDENT   = 3'd2;
	localparam logic [2:0] M_SLASH   = 3'd3;
	localparam logic [2:0] M_LINEC   = 3'd4;
	localparam logic [2:0] M_BLOCK   = 3'd5;
	localparam logic [2:0] M_STAR    = 3'd6;
	localparam logic [2:0] M_DISCARD = 3'd7;

	localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]  LMAX = {LINE_BITS{1'b1}};

	logic [2:0]            mode_q, mode_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic [5:0][7:0]       chars_q, chars_d;
	logic [2:0]            len_q, len_d;
	logic [LINE_BITS-1:0]  line_q, line_d;

	logic [1:0]            n;
	logic [4:0]            tk_kind [3];
	logic [VALUE_BITS-1:0] tk_val  [3];
	logic [LINE_BITS-1:0]  tk_line [3];
	logic                  is_end, lex, bump;
	logic [VALUE_BITS+3:0] acc10;

	assign acc10 = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (VALUE_BITS+4)'(src_byte[3:0]);

	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		chars_d = chars_q;
		len_d   = len_q;
		line_d  = line_q;
		n       = 2'd0;
		lex     = 1'b0;
		bump    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			tk_kind[i] = K_EOF;
			tk_val[i]  = '0;
			tk_line[i] = line_q;
		end
		is_end = (src_byte == CH_NUL) || end_of_source;

		if (mode_q != M_DISCARD) begin
			if (src_byte != CH_NUL) begin
				case (mode_q)
					M_LINEC: begin
						if (src_byte == CH_NL) lex = 1'b1;
					end
					M_BLOCK: begin
						if (src_byte == CH_STAR) mode_d = M_STAR;
						else if (src_byte == CH_NL) bump = 1'b1;
					end
					M_STAR: begin
						if (src_byte == CH_SLASH) mode_d = M_IDLE;
						else if (src_byte != CH_STAR) begin
							bump   = (src_byte == CH_NL);
							mode_d = M_BLOCK;
						end
					end
					M_SLASH: begin
						if (src_byte == CH_SLASH) mode_d = M_LINEC;
						else if (src_byte == CH_STAR) mode_d = M_BLOCK;
						else begin
							tk_kind[n] = K_DIV;
							n   = n + 2'd1;
							lex = 1'b1;
						end
					end
					M_NUM: begin
						if (is_digit(src_byte)) begin
							acc_d = (acc10 > (VALUE_BITS+4)'(VMAX)) ? VMAX : acc10[VALUE_BITS-1:0];
						end else begin
							tk_kind[n] = K_NUMBER;
							tk_val[n]  = acc_q;
							n   = n + 2'd1;
							lex = 1'b1;
						end
					end
					M_IDENT: begin
						if (is_alpha(src_byte) || is_digit(src_byte)) begin
							if (len_q < 3'd6) chars_d[len_q] = src_byte;
							if (len_q < 3'd7) len_d = len_q + 3'd1;
						end else begin
							tk_kind[n] = kw_kind(chars_q, len_q);
							n   = n + 2'd1;
							lex = 1'b1;
						end
					end
					default: lex = 1'b1;
				endcase

				if (lex) begin
					mode_d = M_IDLE;
					case (src_byte)
						CH_SPACE, CH_TAB, CH_CR: ;
						CH_NL:    bump = 1'b1;
						CH_SLASH: mode_d = M_SLASH;
						8'h2B: begin tk_kind[n] = K_PLUS;   n = n + 2'd1; end
						8'h2D: begin tk_kind[n] = K_MINUS;  n = n + 2'd1; end
						CH_STAR: begin tk_kind[n] = K_MUL;  n = n + 2'd1; end
						8'h28: begin tk_kind[n] = K_LPAREN; n = n + 2'd1; end
						8'h29: begin tk_kind[n] = K_RPAREN; n = n + 2'd1; end
						8'h7B: begin tk_kind[n] = K_LBRACE; n = n + 2'd1; end
						8'h7D: begin tk_kind[n] = K_RBRACE; n = n + 2'd1; end
						8'h3B: begin tk_kind[n] = K_SEMI;   n = n + 2'd1; end
						8'h3D: begin tk_kind[n] = K_ASSIGN; n = n + 2'd1; end
						8'h3C: begin tk_kind[n] = K_LT;     n = n + 2'd1; end
						8'h3E: begin tk_kind[n] = K_GT;     n = n + 2'd1; end
						default: begin
							if (is_digit(src_byte)) begin
								mode_d = M_NUM;
								acc_d  = VALUE_BITS'(src_byte[3:0]);
							end else if (is_alpha(src_byte)) begin
								mode_d     = M_IDENT;
								chars_d    = '0;
								chars_d[0] = src_byte;
								len_d      = 3'd1;
							end else begin
								tk_kind[n] = K_ERROR;
								n      = n + 2'd1;
								mode_d = M_DISCARD;
							end
						end
					endcase
				end
			end

			if (bump && line_q != LMAX) line_d = line_q + LINE_BITS'(1);

			// end of source: flush whatever is pending, then eof, unless the source is being discarded
			if (is_end && mode_d != M_DISCARD) begin
				if (mode_d == M_NUM) begin
					tk_kind[n] = K_NUMBER;
					tk_val[n]  = acc_d;
					tk_line[n] = line_d;
					n = n + 2'd1;
				end else if (mode_d == M_IDENT) begin
					tk_kind[n] = kw_kind(chars_d, len_d);
					tk_line[n] = line_d;
					n = n + 2'd1;
				end else if (mode_d == M_SLASH) begin
					tk_kind[n] = K_DIV;
					tk_line[n] = line_d;
					n = n + 2'd1;
				end
				tk_kind[n] = K_EOF;
				tk_line[n] = line_d;
				n = n + 2'd1;
			end
		end

		if (is_end) begin
			mode_d  = M_IDLE;
			acc_d   = '0;
			chars_d = '0;
			len_d   = 3'd0;
			line_d  = LINE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			chars_q <= '0;
			len_q   <= 3'd0;
			line_q  <= LINE_BITS'(1);
		end else if (take) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			chars_q <= chars_d;
			len_q   <= len_d;
			line_q  <= line_d;
		end
	end

	assign push   = take && (n != 2'd0);
	assign bundle = {tk_line[2], tk_val[2], tk_kind[2],
	                 tk_line[1], tk_val[1], tk_kind[1],
	                 tk_line[0], tk_val[0], tk_kind[0], n};

endmodule

[hdl/csl_queue.sv]
// short queue of token bundles between front and back end
// depends on csl_pkg
module csl_queue import csl_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]  mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assign rdata = mem_q[rp_q];
	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);

endmodule

[hdl/csl_back.sv]
// back end: walks the tokens of the head bundle into the output register
// depends on csl_pkg
module csl_back import csl_pkg::*; #(
	parameter int LINE_BITS  = 16,
	parameter int VALUE_BITS = 31,
	parameter int TOK_W      = KIND_BITS + VALUE_BITS + LINE_BITS,
	parameter int BUN_W      = 2 + 3 * TOK_W,
	parameter int TW         = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [BUN_W-1:0] head,
	input  logic             empty,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [TW-1:0]    m_tdata,
	output logic             m_tlast
);

	logic [1:0]       idx_q;
	logic [1:0]       cnt;
	logic [TOK_W-1:0] tok;
	logic             load, last;
	logic             valid_q, last_q;
	logic [TOK_W-1:0] tok_q;

	assign cnt  = head[1:0];
	assign tok  = head[2 + idx_q*TOK_W +: TOK_W];
	assign load = !empty && (!valid_q || m_tready);
	assign last = (idx_q == cnt - 2'd1);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= tok;
			last_q <= last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TW'(tok_q);
	assign m_tlast  = last_q;

endmodule

[hdl/c_subset_lexer_top.sv]
// top level of the streaming c subset lexer
// depends on csl_pkg, csl_front, csl_queue, csl_back and c_subset_lexer_top_defines.svh

// Streaming lexer for a small C subset. Source bytes arrive on the slave
// stream, one per transfer, with tlast marking the final byte of a source;
// a zero byte also ends the source. Tokens leave on the master stream, one
// per transfer, with tlast set on the last token caused by a given byte.
// Whitespace and both comment forms are skipped in any mix, lines are
// counted (saturating), decimal numbers saturate at 2^VALUE_BITS-1 and
// identifiers are checked against int, return, if, else, for and while.
// An unknown byte gives an error token and the rest of that source is
// dropped without an eof token. The front end scans one byte every cycle
// while the queue has room and writes the one to three tokens of that
// byte, if any, as one entry into a four-entry queue; the back end drains
// one token per cycle into the output register while m_tready allows. The
// sustained rate is one byte per cycle as long as bytes give at most one
// token each and the output is not stalled; a byte that gives k tokens
// needs k output transfers, which the queue absorbs until it fills.
`include "c_subset_lexer_top_defines.svh"
module c_subset_lexer_top import csl_pkg::*; #(
	parameter int LINE_BITS  = 16,
	parameter int VALUE_BITS = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // src_byte
	input  logic          s_tlast,   // end_of_source
	output logic          m_tvalid,
	input  logic          m_tready,
	// token_kind [4:0], number_value, line_number, zero fill to whole bytes
	output logic [((KIND_BITS+VALUE_BITS+LINE_BITS+7)/8)*8-1:0] m_tdata,
	output logic          m_tlast    // last_of_run
);

	localparam int TOK_W = KIND_BITS + VALUE_BITS + LINE_BITS;
	localparam int BUN_W = 2 + 3 * TOK_W;
	localparam int TW    = ((TOK_W + 7) / 8) * 8;

	logic             take, push, pop, full, empty;
	logic [BUN_W-1:0] bundle, head;

	// byte transfer
	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	csl_front #(
		.LINE_BITS(LINE_BITS), .VALUE_BITS(VALUE_BITS), .TOK_W(TOK_W), .BUN_W(BUN_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.src_byte(s_tdata), .end_of_source(s_tlast),
		.push(push), .bundle(bundle)
	);

	// decouples scanning from token output
	csl_queue #(.W(BUN_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(bundle), .pop(pop), .rdata(head),
		.full(full), .empty(empty)
	);

	csl_back #(
		.LINE_BITS(LINE_BITS), .VALUE_BITS(VALUE_BITS), .TOK_W(TOK_W),
		.BUN_W(BUN_W), .TW(TW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// queue never written when full nor read when empty
	`CSL_ASSERT_IMP(a_no_overflow, push, !full)
	`CSL_ASSERT_IMP(a_no_underflow, pop, !empty)
	// a bundle in the queue always holds at least one token
	`CSL_ASSERT_IMP(a_bundle_nonempty, !empty, head[1:0] != 2'd0)
	// only number tokens carry a value
	`CSL_ASSERT_IMP(a_value_only_number,
		m_tvalid && m_tdata[KIND_BITS-1:0] != K_NUMBER,
		m_tdata[KIND_BITS+VALUE_BITS-1:KIND_BITS] == '0)

endmodule
